// File: rtl/acube_pkg.sv
// ============================================================================
// acube_pkg: shared constants, types and helpers for the ambient cube block
// Holds field widths, register indexes and the front-to-back item record.
// ============================================================================
package acube_pkg;

    localparam int ENTRY_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int WEIGHT_BITS      = 16;
    localparam int NUM_W            = 17;   // vertex_z - bottom
    localparam int QUO_W            = WEIGHT_BITS + 1;
    localparam int DIV_STEPS        = QUO_W;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_W       = 2;
    localparam int PROD_W           = 16 + ENTRY_WIDTH + 1;
    localparam int DSUM_W           = PROD_W + 2;
    localparam int CVAL_W           = DSUM_W - NORMAL_FRAC_BITS + 2;
    localparam int BLEND_W          = CVAL_W + WEIGHT_BITS + 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_XY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ZA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_XY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = 3'd5;

    // weight class decided in the front part
    typedef enum logic [1:0] {
        WC_ZERO = 2'd0,
        WC_ONE  = 2'd1,
        WC_DIV  = 2'd2
    } t_wclass;

    // item record passed from front to back
    typedef struct packed {
        logic signed [15:0]      nx;
        logic signed [15:0]      ny;
        logic signed [15:0]      nz;
        t_wclass                 wclass;
        logic [NUM_W-1:0]        num;
        logic [NUM_W-1:0]        den;
    } t_item;

    function automatic logic signed [15:0] sat16(input logic signed [BLEND_W-1:0] x);
        logic signed [BLEND_W-1:0] hi;
        logic signed [BLEND_W-1:0] lo;
        hi = BLEND_W'(32767);
        lo = -BLEND_W'(32768);
        if (x > hi) begin
            return 16'sh7fff;
        end else if (x < lo) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

endpackage

// File: rtl/ambient_cube_height_blend_eval.sv
// ============================================================================
// ambient_cube_height_blend_eval: two-cube ambient lighting with height blend
// Configuration registers, input queue and evaluation pipeline.
// ============================================================================
// Path: input queue, weight divider, product, sum and blend registers, output skid buffer.
// Throughput: one item per cycle while the skid buffer has room; the 17-stage weight divider is pipelined.
// Reset: synchronous, active low; clears registers, queue and pipeline valids.
module ambient_cube_height_blend_eval
    import acube_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [63:0]              s_axis_tdata,  // normal_x, normal_y, normal_z, vertex_z
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [47:0]              m_axis_tdata   // total_light, ambient_light, direct_light
);

    logic [63:0]        r_low_xy, r_high_xy;
    logic [47:0]        r_low_za, r_high_za;
    logic signed [15:0] r_bottom, r_top;
    logic               w_qv, w_qr;
    t_item              w_qi;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_xy <= '0; r_low_za <= '0; r_high_xy <= '0; r_high_za <= '0;
            r_bottom <= '0; r_top <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOW_XY:  r_low_xy  <= i_cfg_data;
                REG_LOW_ZA:  r_low_za  <= i_cfg_data[47:0];
                REG_HIGH_XY: r_high_xy <= i_cfg_data;
                REG_HIGH_ZA: r_high_za <= i_cfg_data[47:0];
                REG_BOTTOM:  r_bottom  <= i_cfg_data[15:0];
                REG_TOP:     r_top     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    acube_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_nx(s_axis_tdata[15:0]), .i_ny(s_axis_tdata[31:16]),
        .i_nz(s_axis_tdata[47:32]), .i_vz(s_axis_tdata[63:48]),
        .i_bottom(r_bottom), .i_top(r_top),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_qi)
    );

    acube_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_qi),
        .i_low_xy(r_low_xy), .i_low_za(r_low_za),
        .i_high_xy(r_high_xy), .i_high_za(r_high_za),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

endmodule

// File: rtl/acube_front.sv
// ============================================================================
// acube_front: input stage
// Accept items, classify the height weight case and queue them for the back.
// ============================================================================
module acube_front
    import acube_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_nx,
    input  logic signed [15:0]  i_ny,
    input  logic signed [15:0]  i_nz,
    input  logic signed [15:0]  i_vz,
    input  logic signed [15:0]  i_bottom,
    input  logic signed [15:0]  i_top,
    output logic                o_valid,
    input  logic                i_ready,
    output t_item               o_item
);

    t_item                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wp, r_rp;
    logic [FIFO_PTR_W:0]    r_cnt;
    logic                   w_push, w_pop;
    logic signed [NUM_W-1:0] w_num, w_den;
    t_item                  w_item;

    // classify the weight: flat box, clamp ends, or needs a divide
    always_comb begin
        w_num = NUM_W'(i_vz) - NUM_W'(i_bottom);
        w_den = NUM_W'(i_top) - NUM_W'(i_bottom);
        w_item.nx = i_nx;
        w_item.ny = i_ny;
        w_item.nz = i_nz;
        w_item.num = w_num;
        w_item.den = w_den;
        if (w_den <= 0) begin
            w_item.wclass = (w_num >= 0) ? WC_ONE : WC_ZERO;
        end else if (w_num <= 0) begin
            w_item.wclass = WC_ZERO;
        end else if (w_num >= w_den) begin
            w_item.wclass = WC_ONE;
        end else begin
            w_item.wclass = WC_DIV;
        end
    end

    assign o_ready = (r_cnt != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    // hold queued items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_PTR_W+1)'(w_push) - (FIFO_PTR_W+1)'(w_pop);
        end
    end

endmodule

// File: rtl/acube_back.sv
// ============================================================================
// acube_back: evaluation pipeline
// Divide for the weight one bit per stage, evaluate both cubes, blend,
// saturate; a two-entry skid buffer at the output.
// ============================================================================
module acube_back
    import acube_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_item               i_item,
    input  logic [63:0]         i_low_xy,
    input  logic [47:0]         i_low_za,
    input  logic [63:0]         i_high_xy,
    input  logic [47:0]         i_high_za,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [47:0]         o_data
);

    localparam int NST = DIV_STEPS + 4;
    localparam int REM_W = NUM_W + 1;

    // ---- pipeline control: advance when the skid buffer has room ----
    logic           w_adv;
    logic [NST-1:0] r_vld;
    logic [1:0]     r_scnt;
    assign w_adv   = (r_scnt == 2'd0) || !r_vld[NST-1] ||
                     (r_scnt == 2'd1 && i_ready);
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // ---- restoring divider: one quotient bit per stage ----
    // Start from num/2 as the partial remainder (below den since num < den),
    // then bring in the low bit of num followed by the weight's zero bits.
    t_item              r_dit [DIV_STEPS+1];
    logic [REM_W-1:0]   r_rem [DIV_STEPS+1];
    logic [QUO_W-1:0]   r_quo [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dit[0] <= i_item;
            r_rem[0] <= REM_W'(i_item.num >> 1);
            r_quo[0] <= '0;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        logic [REM_W-1:0] w_try;
        logic             w_bit;
        logic [WEIGHT_BITS:0] w_dvd;
        always_comb begin
            w_dvd = {r_dit[s].num[0], {WEIGHT_BITS{1'b0}}};
            w_try = {r_rem[s][REM_W-2:0], w_dvd[WEIGHT_BITS-s]};
            w_bit = (w_try >= REM_W'(r_dit[s].den));
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dit[s+1] <= r_dit[s];
                r_rem[s+1] <= w_bit ? w_try - REM_W'(r_dit[s].den) : w_try;
                r_quo[s+1] <= {r_quo[s][QUO_W-2:0], w_bit};
            end
        end
    end

    // ---- weight select and per-axis products ----
    logic [QUO_W-1:0]          r_hw;
    logic signed [PROD_W-1:0]  r_pl [3];
    logic signed [PROD_W-1:0]  r_ph [3];
    logic signed [ENTRY_WIDTH-1:0] r_al, r_ah;
    t_item w_it;
    assign w_it = r_dit[DIV_STEPS];

    function automatic logic signed [PROD_W-1:0] axis(
        input logic signed [15:0] n,
        input logic signed [ENTRY_WIDTH-1:0] p,
        input logic signed [ENTRY_WIDTH-1:0] m);
        logic signed [16:0] an;
        an = (n < 0) ? -17'(n) : 17'(n);
        if (n > 0) return PROD_W'(an * p);
        if (n < 0) return PROD_W'(an * m);
        return '0;
    endfunction

    function automatic logic signed [ENTRY_WIDTH-1:0] ent(input logic [63:0] r, input int i);
        return r[i*ENTRY_WIDTH +: ENTRY_WIDTH];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            unique case (w_it.wclass)
                WC_ZERO: r_hw <= '0;
                WC_ONE:  r_hw <= QUO_W'(1 << WEIGHT_BITS);
                default: r_hw <= r_quo[DIV_STEPS];
            endcase
            r_pl[0] <= axis(w_it.nx, ent(i_low_xy, 0), ent(i_low_xy, 1));
            r_pl[1] <= axis(w_it.ny, ent(i_low_xy, 2), ent(i_low_xy, 3));
            r_pl[2] <= axis(w_it.nz, ent({16'd0, i_low_za}, 0), ent({16'd0, i_low_za}, 1));
            r_ph[0] <= axis(w_it.nx, ent(i_high_xy, 0), ent(i_high_xy, 1));
            r_ph[1] <= axis(w_it.ny, ent(i_high_xy, 2), ent(i_high_xy, 3));
            r_ph[2] <= axis(w_it.nz, ent({16'd0, i_high_za}, 0),
                            ent({16'd0, i_high_za}, 1));
            r_al <= ent({16'd0, i_low_za}, 2);
            r_ah <= ent({16'd0, i_high_za}, 2);
        end
    end

    // ---- sum, round to Q12.4, add ambient ----
    logic [QUO_W-1:0]         r_hw2;
    logic signed [CVAL_W-1:0] r_vl, r_vh;
    logic signed [ENTRY_WIDTH-1:0] r_al2, r_ah2;
    logic signed [DSUM_W-1:0] w_dl, w_dh;
    assign w_dl = DSUM_W'(r_pl[0]) + DSUM_W'(r_pl[1]) + DSUM_W'(r_pl[2])
                + DSUM_W'(1 << (NORMAL_FRAC_BITS-1));
    assign w_dh = DSUM_W'(r_ph[0]) + DSUM_W'(r_ph[1]) + DSUM_W'(r_ph[2])
                + DSUM_W'(1 << (NORMAL_FRAC_BITS-1));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hw2 <= r_hw;
            r_vl  <= CVAL_W'(w_dl >>> NORMAL_FRAC_BITS) + CVAL_W'(r_al);
            r_vh  <= CVAL_W'(w_dh >>> NORMAL_FRAC_BITS) + CVAL_W'(r_ah);
            r_al2 <= r_al;
            r_ah2 <= r_ah;
        end
    end

    // ---- blend as lo + hw*(hi-lo), round, saturate ----
    logic signed [BLEND_W-1:0] w_bt, w_ba, w_tot, w_amb, w_dir;
    logic signed [BLEND_W-1:0] w_hws;
    logic [47:0] r_res;
    always_comb begin
        w_hws = BLEND_W'(r_hw2);
        w_bt  = (BLEND_W'(r_vl) <<< WEIGHT_BITS)
              + w_hws * (BLEND_W'(r_vh) - BLEND_W'(r_vl))
              + BLEND_W'(1 << (WEIGHT_BITS-1));
        w_ba  = (BLEND_W'(r_al2) <<< WEIGHT_BITS)
              + w_hws * (BLEND_W'(r_ah2) - BLEND_W'(r_al2))
              + BLEND_W'(1 << (WEIGHT_BITS-1));
        w_tot = w_bt >>> WEIGHT_BITS;
        w_amb = w_ba >>> WEIGHT_BITS;
        w_dir = w_tot - w_amb;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= {sat16(w_dir), sat16(w_amb), sat16(w_tot)};
        end
    end

    // ---- two-entry skid buffer ----
    logic [47:0] r_sk [2];
    logic        r_sh;
    logic        w_in, w_out;
    assign w_in  = w_adv && r_vld[NST-1];
    assign w_out = o_valid && i_ready;
    assign o_valid = (r_scnt != 2'd0);
    assign o_data  = r_sk[r_sh];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
            r_sh   <= 1'b0;
        end else begin
            r_scnt <= r_scnt + 2'(w_in) - 2'(w_out);
            if (w_out) r_sh <= ~r_sh;
        end
    end

    // write at the tail: head plus current fill
    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_sk[r_sh ^ r_scnt[0]] <= r_res;
        end
    end

endmodule

// File: rtl/acube_checker.sv
// ============================================================================
// acube_checker: port-level checks for the ambient cube block
// Watches the stream ports over time; bound to the top level.
// ============================================================================
module acube_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // stalled output holds its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // direct equals total minus ambient when total is off its limits and shares ambient's sign
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[15] == m_axis_tdata[31]) &&
        (m_axis_tdata[15:0] != 16'h7fff) && (m_axis_tdata[15:0] != 16'h8000) |->
        m_axis_tdata[47:32] == m_axis_tdata[15:0] - m_axis_tdata[31:16])
        else $error("direct light mismatch");

    // input side accepts after reset
    a_rdy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> s_axis_tready)
        else $error("not ready after reset");

endmodule

bind ambient_cube_height_blend_eval acube_checker u_acube_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for ambient_cube_height_blend_eval
// Drives vertex items through the stream input under several idle and stall
// patterns, predicts each shaded result from the register settings and
// compares every output item field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import acube_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;   // normal_x, normal_y, normal_z, vertex_z
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // total_light, ambient_light, direct_light

    typedef struct packed {
        logic [15:0] direct;
        logic [15:0] ambient;
        logic [15:0] total;
    } t_shade;

    // predictor copy of the registers
    logic [63:0] low_xy, high_xy;
    logic [47:0] low_za, high_za;
    logic signed [15:0] bottom_z, top_z;

    t_shade shade_q[$];
    int     n_errors;
    int     send_idle_pct;
    int     recv_stall_pct;
    logic   hold_recv;

    ambient_cube_height_blend_eval DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint entry_of(logic [63:0] r, int idx);
        return longint'($signed(r[idx*16 +: 16]));
    endfunction

    function automatic longint floor_shr(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint round_shr(longint x, int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic logic [15:0] clamp16(longint x);
        if (x > 32767) return 16'h7fff;
        if (x < -32768) return 16'h8000;
        return x[15:0];
    endfunction

    function automatic longint axis_light(longint n, longint pos, longint neg);
        if (n > 0) return n * pos;
        if (n < 0) return -n * neg;
        return 0;
    endfunction

    function automatic longint cube_light(logic [63:0] xy, logic [47:0] za,
                                          longint nx, longint ny, longint nz);
        longint d;
        d = axis_light(nx, entry_of(xy, 0), entry_of(xy, 1))
          + axis_light(ny, entry_of(xy, 2), entry_of(xy, 3))
          + axis_light(nz, entry_of({16'h0, za}, 0), entry_of({16'h0, za}, 1));
        return round_shr(d, NORMAL_FRAC_BITS) + entry_of({16'h0, za}, 2);
    endfunction

    function automatic t_shade shade_vertex(logic [63:0] d);
        longint nx, ny, nz, vz, num, den, hw, lw, tot, amb;
        t_shade r;
        nx = $signed(d[15:0]);
        ny = $signed(d[31:16]);
        nz = $signed(d[47:32]);
        vz = $signed(d[63:48]);
        num = vz - longint'(bottom_z);
        den = longint'(top_z) - longint'(bottom_z);
        if (den <= 0) hw = (num >= 0) ? 65536 : 0;
        else if (num <= 0) hw = 0;
        else if (num >= den) hw = 65536;
        else hw = (num << 16) / den;
        lw = 65536 - hw;
        tot = round_shr(lw * cube_light(low_xy, low_za, nx, ny, nz)
                      + hw * cube_light(high_xy, high_za, nx, ny, nz), 16);
        amb = round_shr(lw * entry_of({16'h0, low_za}, 2)
                      + hw * entry_of({16'h0, high_za}, 2), 16);
        r.total   = clamp16(tot);
        r.ambient = clamp16(amb);
        r.direct  = clamp16(tot - amb);
        return r;
    endfunction

    // receiver: random stall, long hold-off, and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_recv) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                t_shade got, want;
                got = m_axis_tdata;
                if (shade_q.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, got);
                    n_errors++;
                end else begin
                    want = shade_q.pop_front();
                    if (got.total !== want.total) begin
                        $display("%0t: total_light expected %h actual %h",
                                 $time, want.total, got.total);
                        n_errors++;
                    end
                    if (got.ambient !== want.ambient) begin
                        $display("%0t: ambient_light expected %h actual %h",
                                 $time, want.ambient, got.ambient);
                        n_errors++;
                    end
                    if (got.direct !== want.direct) begin
                        $display("%0t: direct_light expected %h actual %h",
                                 $time, want.direct, got.direct);
                        n_errors++;
                    end
                end
            end
        end
    end

    // offer one item, honoring the sender idle rate; valid stays up after accept
    task automatic send_vertex(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                               logic [15:0] vz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vz, nz, ny, nx};
        do @(posedge i_clk); while (!s_axis_tready);
        shade_q.push_back(shade_vertex({vz, nz, ny, nx}));
    endtask

    // drop valid and wait for every expected result
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (shade_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (shade_q.size() != 0) begin
            $display("%0t: results expected %0d actual 0", $time, shade_q.size());
            n_errors++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_LOW_XY:  low_xy   = val;
            REG_LOW_ZA:  low_za   = val[47:0];
            REG_HIGH_XY: high_xy  = val;
            REG_HIGH_ZA: high_za  = val[47:0];
            REG_BOTTOM:  bottom_z = val[15:0];
            REG_TOP:     top_z    = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'hffff;
            2: return 16'h7fff;
            3: return 16'h0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [63:0] rand_cube_word();
        case ($urandom_range(3))
            0: return {4{16'h7fff}};
            1: return {4{16'h8000}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic program_all(logic [63:0] lxy, logic [63:0] lza, logic [63:0] hxy,
                               logic [63:0] hza, logic [15:0] bz, logic [15:0] tz);
        write_reg(REG_LOW_XY, lxy);
        write_reg(REG_LOW_ZA, lza);
        write_reg(REG_HIGH_XY, hxy);
        write_reg(REG_HIGH_ZA, hza);
        write_reg(REG_BOTTOM, {48'h0, bz});
        write_reg(REG_TOP, {48'h0, tz});
    endtask

    // field extremes, zero normals, flat and inverted box
    task automatic test_directed();
        program_all(64'hfff0_0010_8000_7fff, 64'h0000_0020_ffe0_0040,
                    64'h7fff_8000_0100_ff00, 64'h0000_7fff_8000_1234,
                    16'hff00, 16'h0100);
        send_vertex(16'h0, 16'h0, 16'h0, 16'h0);
        send_vertex(16'h4000, 16'h0, 16'h0, 16'hff00);
        send_vertex(16'hc000, 16'h0, 16'h0, 16'h0100);
        send_vertex(16'h0, 16'h4000, 16'hc000, 16'h8000);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h0001);
        send_vertex(16'hffff, 16'h0001, 16'hffff, 16'hfeff);
        send_vertex(16'h2d41, 16'hd2bf, 16'h2d41, 16'h0080);
        drain();
        // extreme entries: cube values far beyond the 16-bit output range
        program_all({4{16'h7fff}}, {16'h0, 16'h7fff, 16'h7fff, 16'h7fff},
                    {4{16'h8000}}, {16'h0, 16'h8000, 16'h8000, 16'h8000},
                    16'h8000, 16'h7fff);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
        send_vertex(16'h4000, 16'h4000, 16'h4000, 16'hc000);
        drain();
        // flat box, then inverted box
        write_reg(REG_BOTTOM, 64'h10);
        write_reg(REG_TOP, 64'h10);
        send_vertex(16'h4000, 16'h0, 16'h0, 16'h10);
        send_vertex(16'h4000, 16'h0, 16'h0, 16'h0f);
        drain();
        write_reg(REG_TOP, 64'hfff0);
        send_vertex(16'h0, 16'hc000, 16'h0, 16'h10);
        send_vertex(16'h0, 16'hc000, 16'h0, 16'h0f);
        send_vertex(16'h0, 16'hc000, 16'h0, 16'h7fff);
        drain();
        // unknown register indexes are ignored
        write_reg(3'd6, 64'hffff_ffff_ffff_ffff);
        write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
        send_vertex(16'h0, 16'h0, 16'h4000, 16'h8000);
        drain();
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        logic [15:0] bz, tz;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        bz = 16'($urandom);
        tz = ($urandom_range(4) == 0) ? 16'($urandom) : 16'(bz + $urandom_range(4000));
        program_all(rand_cube_word(), rand_cube_word(), rand_cube_word(),
                    rand_cube_word(), bz, tz);
        repeat (n_items) begin
            logic [15:0] vz;
            case ($urandom_range(5))
                0: vz = 16'($urandom);
                1: vz = bz;
                2: vz = tz;
                default: vz = 16'(bz + $urandom_range(4100) - 50);
            endcase
            send_vertex(rand_normal(), rand_normal(), rand_normal(), vz);
        end
        drain();
    endtask

    // receiver holds off while the sender fills the block, then full drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // count the hold-off in its own process
        fork
            begin
                hold_recv <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_recv <= 1'b0;
            end
        join_none
        repeat (60) send_vertex(rand_normal(), rand_normal(), rand_normal(), 16'($urandom));
        drain();
        repeat (10) send_vertex(rand_normal(), rand_normal(), rand_normal(), 16'($urandom));
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        n_errors      = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv     = 1'b0;
        low_xy = '0; high_xy = '0; low_za = '0; high_za = '0;
        bottom_z = '0; top_z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(250, 0, 0);
        test_random(250, 70, 0);
        test_random(250, 0, 70);
        test_random(250, 24, 24);
        test_random(250, 0, 0);
        test_random(250, 24, 24);
        test_random(250, 70, 70);
        test_backpressure();

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
